// File: hw/rtl/functional_unit_pool_pipeline_defines.svh
// Assertion macros for the functional unit pool pipeline.
// Taken in by every RTL file that carries concurrent checks; needs clk and arst_n in scope.
`ifndef FUNCTIONAL_UNIT_POOL_PIPELINE_DEFINES_SVH
`define FUNCTIONAL_UNIT_POOL_PIPELINE_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define FUPP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fupp: check failed");
// same-cycle implication
`define FUPP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fupp: implication failed");
// next-cycle implication
`define FUPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fupp: next-cycle implication failed");
`else
`define FUPP_ASSERT(lbl, cond)
`define FUPP_ASSERT_IMP(lbl, ante, cons)
`define FUPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/fupp_pkg.sv
// Shared constants, types and cell placement functions for the functional unit pool pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fupp_pkg;

	// unit counts per pool, each 1..8
	localparam int UNITS_T0 = 2;
	localparam int UNITS_T1 = 2;
	localparam int UNITS_T2 = 2;
	localparam int NCELL    = UNITS_T0 + UNITS_T1 + UNITS_T2;

	// tag bits kept in the stages; the input tag field is 8 bits wide
	localparam int TAG_W  = 8;
	localparam int KEEP_W = (TAG_W < 8) ? TAG_W : 8;

	// stages in the deepest pool
	localparam int STAGES = 3;

	// field codes
	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;
	localparam logic REPLY_ISSUE = 1'b0;
	localparam logic REPLY_DONE  = 1'b1;

	// issue request rippling along the cell row
	typedef struct packed {
		logic              pend;
		logic [1:0]        utype;
		logic [KEEP_W-1:0] tag;
	} iss_t;

	// completion report slot, shifted towards the head of the row
	typedef struct packed {
		logic              v;
		logic [KEEP_W-1:0] tag;
		logic [1:0]        utype;
		logic [2:0]        unit;
	} slot_t;

	// pool of the cell at a given place in the row
	function automatic logic [1:0] cell_type_of(input int i);
		logic [1:0] t;
		if (i < UNITS_T0) begin
			t = 2'd0;
		end else if (i < UNITS_T0 + UNITS_T1) begin
			t = 2'd1;
		end else begin
			t = 2'd2;
		end
		return t;
	endfunction

	// unit index within its pool
	function automatic logic [2:0] cell_unit_of(input int i);
		int u;
		if (i < UNITS_T0) begin
			u = i;
		end else if (i < UNITS_T0 + UNITS_T1) begin
			u = i - UNITS_T0;
		end else begin
			u = i - UNITS_T0 - UNITS_T1;
		end
		return 3'(u);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fupp_cell.sv
// One functional unit: up to three pipeline stages plus one completion report slot.
// Depends on fupp_pkg; cells are chained by the top level.
`timescale 1ns / 1ps
`default_nettype none

module fupp_cell import fupp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] cell_type,  // pool, also index of the last stage
	input  wire logic [2:0] cell_unit,
	input  wire logic       tick,
	input  wire iss_t       iss_i,      // request from the lower neighbour
	output iss_t            iss_o,      // request left over for the upper neighbour
	input  wire slot_t      slot_up_i,  // slot of the upper neighbour
	input  wire logic       open_dn_i,  // lower neighbour takes a slot this cycle
	output slot_t           slot_o,
	output logic            open_o
);

	logic              sv_q [STAGES];
	logic [KEEP_W-1:0] st_q [STAGES];
	logic              sv_n [STAGES];
	logic [KEEP_W-1:0] st_n [STAGES];
	logic              slot_v_q;
	logic [KEEP_W-1:0] slot_tag_q;
	logic [1:0]        slot_type_q;
	logic [2:0]        slot_unit_q;
	logic              claim;

	// issue: take the request if this unit matches and stage 0 is free
	assign claim = iss_i.pend && (iss_i.utype == cell_type) && !sv_q[0];
	always_comb begin
		iss_o      = iss_i;
		iss_o.pend = iss_i.pend && !claim;
	end

	// tick: retire the last stage, then close up bubbles from the top down
	always_comb begin
		for (int s = 0; s < STAGES; s++) begin
			sv_n[s] = sv_q[s];
			st_n[s] = st_q[s];
		end
		if (tick) begin
			sv_n[cell_type] = 1'b0;
			for (int s = STAGES - 1; s > 0; s--) begin
				if ((s <= int'(cell_type)) && !sv_n[s]) begin
					sv_n[s]     = sv_n[s-1];
					st_n[s]     = st_n[s-1];
					sv_n[s-1]   = 1'b0;
				end
			end
		end
		if (claim) begin
			sv_n[0] = 1'b1;
			st_n[0] = iss_i.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STAGES; s++) begin
				sv_q[s] <= 1'b0;
			end
		end else begin
			for (int s = 0; s < STAGES; s++) begin
				sv_q[s] <= sv_n[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < STAGES; s++) begin
			st_q[s] <= st_n[s];
		end
	end

	// report slot: loaded on a tick, otherwise shifts down whenever it can
	assign open_o = !slot_v_q || open_dn_i;
	assign slot_o = {slot_v_q, slot_tag_q, slot_type_q, slot_unit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_q <= 1'b0;
		end else if (tick) begin
			slot_v_q <= sv_q[cell_type];
		end else if (open_o) begin
			slot_v_q <= slot_up_i.v;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			slot_tag_q  <= st_q[cell_type];
			slot_type_q <= cell_type;
			slot_unit_q <= cell_unit;
		end else if (open_o) begin
			slot_tag_q  <= slot_up_i.tag;
			slot_type_q <= slot_up_i.utype;
			slot_unit_q <= slot_up_i.unit;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/functional_unit_pool_pipeline.sv
// Functional unit pool pipeline: the row of unit cells, the stream ports and the output register.
// Depends on fupp_pkg, fupp_cell and functional_unit_pool_pipeline_defines.svh.
//
// An issue word: the request ripples along the row of unit cells, the lowest free unit of the
// requested pool claims it, and the accept/reject reply goes to the output register. A tick
// word retires every last stage into the cells' report slots and advances the stages; the
// reports then move one cell per cycle towards the head of the row while the output is not
// stalled, and leave it at most one per cycle. The next input word is taken once all slots
// have drained and the output register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "functional_unit_pool_pipeline_defines.svh"

module functional_unit_pool_pipeline import fupp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [1:0] unit_type, [9:2] tag, [15:10] zero
	input  wire logic        s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [0] accepted, [8:1] done_tag, [10:9] done_type,
	                                    // [13:11] done_unit, [15:14] zero
	output logic             m_tuser,   // [0] reply_kind
	output logic             m_tlast
);

	iss_t        iss_w  [NCELL+1];
	slot_t       slot_w [NCELL];
	logic        open_w [NCELL];
	logic [NCELL-1:0] slot_v;
	logic        any_slot;
	logic        in_acc, iss_acc, tick_acc, pop, last_hd, out_free;

	logic        out_v_q, out_kind_q, out_acc_q, out_last_q;
	logic [7:0]  out_tag_q;
	logic [1:0]  out_type_q;
	logic [2:0]  out_unit_q;

	// input handshake
	assign out_free = !out_v_q || m_tready;
	assign s_tready = !any_slot && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign iss_acc  = in_acc && (s_tuser == KIND_ISSUE);
	assign tick_acc = in_acc && (s_tuser == KIND_TICK);

	// request enters at cell 0
	assign iss_w[0] = '{pend: iss_acc, utype: s_tdata[1:0], tag: s_tdata[2 +: KEEP_W]};

	// row of unit cells, pool order then unit order
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		slot_t up;
		logic  dn_open;
		if (i == NCELL - 1) begin : g_top
			assign up = '0;
		end else begin : g_mid
			assign up = slot_w[i+1];
		end
		if (i == 0) begin : g_head
			assign dn_open = pop;
		end else begin : g_body
			assign dn_open = open_w[i-1];
		end
		fupp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_type (cell_type_of(i)),
			.cell_unit (cell_unit_of(i)),
			.tick      (tick_acc),
			.iss_i     (iss_w[i]),
			.iss_o     (iss_w[i+1]),
			.slot_up_i (up),
			.open_dn_i (dn_open),
			.slot_o    (slot_w[i]),
			.open_o    (open_w[i])
		);
		assign slot_v[i] = slot_w[i].v;
	end

	// head of the report chain
	assign any_slot = |slot_v;
	assign pop      = slot_v[0] && out_free;
	assign last_hd  = !(|(slot_v >> 1));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (iss_acc || pop) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_acc) begin
			out_kind_q <= REPLY_ISSUE;
			out_acc_q  <= !iss_w[NCELL].pend;
			out_tag_q  <= '0;
			out_type_q <= '0;
			out_unit_q <= '0;
			out_last_q <= 1'b1;
		end else if (pop) begin
			out_kind_q <= REPLY_DONE;
			out_acc_q  <= 1'b0;
			out_tag_q  <= 8'(slot_w[0].tag);
			out_type_q <= slot_w[0].utype;
			out_unit_q <= slot_w[0].unit;
			out_last_q <= last_hd;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_unit_q, out_type_q, out_tag_q, out_acc_q};

	// checks
	`FUPP_ASSERT_NEXT(a_drain_last, pop && last_hd, !any_slot)
	`FUPP_ASSERT(a_one_load, !(iss_acc && pop))
	`FUPP_ASSERT_IMP(a_reply_last, m_tvalid && (m_tuser == REPLY_ISSUE), m_tlast)
	`FUPP_ASSERT_IMP(a_open_idle, !any_slot, open_w[NCELL-1])

endmodule

`default_nettype wire
